/* hw/rtl/qlv_pkg.sv */
// ----------------------------------------------------------------------------
// qlv_pkg
// Shared types and codes for the quoted literal validator.
// ----------------------------------------------------------------------------
package qlv_pkg;

  localparam int LEN_W = 12;

  localparam logic [1:0] ST_PENDING   = 2'd0;
  localparam logic [1:0] ST_ACCEPTED  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_NOT_LIT   = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] length;
  } scan_res_t;

endpackage

/* hw/rtl/qlv_text_if.sv */
// ----------------------------------------------------------------------------
// qlv_text_if
// Source byte channel: one raw byte per request plus an end-of-text flag.
// ----------------------------------------------------------------------------
interface qlv_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_ends;

  modport source (output valid, output text_byte, output text_ends, input ready);
  modport sink   (input valid, input text_byte, input text_ends, output ready);
endinterface

/* hw/rtl/qlv_scan_if.sv */
// ----------------------------------------------------------------------------
// qlv_scan_if
// Status channel: one scan status and covered length per request.
// ----------------------------------------------------------------------------
interface qlv_scan_if;
  logic        valid;
  logic        ready;
  logic [1:0]  scan_status;
  logic [11:0] covered_length;

  modport source (output valid, output scan_status, output covered_length, input ready);
  modport sink   (input valid, input scan_status, input covered_length, output ready);
endinterface

/* hw/rtl/qlv_core.sv */
// ----------------------------------------------------------------------------
// qlv_core
// Scan state and per-byte next-state logic of the literal validator.
// ----------------------------------------------------------------------------
module qlv_core
  import qlv_pkg::*;
#(
  parameter int MAX_LITERAL_BYTES = 4095
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] text_byte,
  input  logic       text_ends,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  output scan_res_t  res
);

  localparam int LEN_CAP_INT = (MAX_LITERAL_BYTES < 4095) ? MAX_LITERAL_BYTES : 4095;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_BODY     = 4'd1;
  localparam logic [3:0] PH_ESC      = 4'd2;
  localparam logic [3:0] PH_HEX_HI   = 4'd3;
  localparam logic [3:0] PH_HEX_LO   = 4'd4;
  localparam logic [3:0] PH_U_OPEN   = 4'd5;
  localparam logic [3:0] PH_U_FIRST  = 4'd6;
  localparam logic [3:0] PH_U_DIGITS = 4'd7;
  localparam logic [3:0] PH_UTF_CONT = 4'd8;
  localparam logic [3:0] PH_RECOVER  = 4'd9;

  localparam logic [1:0] GO_ON     = 2'd0;
  localparam logic [1:0] GO_ACCEPT = 2'd1;
  localparam logic [1:0] GO_ERROR  = 2'd2;

  localparam logic [20:0] SCALAR_MAX = 21'h10FFFF;

  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_scalar(input logic [20:0] v);
    return (v <= SCALAR_MAX) && !(v >= 21'h00D800 && v <= 21'h00DFFF);
  endfunction

  logic             literal_kind;
  logic [3:0]       phase, phase_next;
  logic [1:0]       cont_left, cont_left_next;
  logic [20:0]      cp, cp_next;
  logic [1:0]       len_class, len_class_next;
  logic             us_pend, us_pend_next;
  logic             rune_seen, rune_seen_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [LEN_W-1:0] rec_len, rec_len_next;
  logic             rec_closed, rec_closed_next;

  logic [7:0]       quote;
  logic             term;
  logic [4:0]       hex;
  logic [1:0]       go;
  logic             clear;
  logic [20:0]      cp_shift;
  logic [20:0]      min_val;
  logic [24:0]      acc;

  assign quote    = literal_kind ? 8'h27 : 8'h22;
  assign term     = (text_byte == quote) || (text_byte == 8'h0A) || (text_byte == 8'h0D);
  assign hex      = hex_decode(text_byte);
  assign cp_shift = {cp[14:0], text_byte[5:0]};
  assign acc      = {cp, hex[3:0]};

  always_comb begin
    unique case (len_class)
      2'd0:    min_val = 21'h000080;
      2'd1:    min_val = 21'h000800;
      default: min_val = 21'h010000;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    cont_left_next  = cont_left;
    cp_next         = cp;
    len_class_next  = len_class;
    us_pend_next    = us_pend;
    rune_seen_next  = rune_seen;
    byte_count_next = byte_count;
    rec_len_next    = rec_len;
    rec_closed_next = rec_closed;
    res.status      = ST_PENDING;
    res.length      = '0;
    go              = GO_ON;
    clear           = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (text_byte != quote) begin
          res.status = ST_NOT_LIT;
        end else begin
          phase_next      = PH_BODY;
          byte_count_next = LEN_W'(1);
          rec_len_next    = LEN_W'(1);
          if (text_ends) begin
            res.status = ST_MALFORMED;
            res.length = LEN_W'(1);
            clear      = 1'b1;
          end
        end
      end
      PH_RECOVER: begin
        if (term) begin
          res.status = ST_MALFORMED;
          res.length = rec_len;
          clear      = 1'b1;
        end else begin
          rec_len_next = (rec_len < LEN_CAP) ? rec_len + 1'b1 : rec_len;
          if (text_ends) begin
            res.status = ST_MALFORMED;
            res.length = rec_len_next;
            clear      = 1'b1;
          end
        end
      end
      default: begin
        byte_count_next = (byte_count < LEN_CAP) ? byte_count + 1'b1 : byte_count;
        if (!rec_closed) begin
          if (term) begin
            rec_closed_next = 1'b1;
          end else begin
            rec_len_next = (rec_len < LEN_CAP) ? rec_len + 1'b1 : rec_len;
          end
        end

        unique case (phase)
          PH_BODY: begin
            if (literal_kind && rune_seen) begin
              go = (text_byte == quote) ? GO_ACCEPT : GO_ERROR;
            end else if (text_byte == quote) begin
              go = literal_kind ? GO_ERROR : GO_ACCEPT;
            end else if (text_byte == 8'h5C) begin
              phase_next = PH_ESC;
            end else if (text_byte == 8'h09 || text_byte == 8'h0A || text_byte == 8'h0D) begin
              go = GO_ERROR;
            end else if (text_byte < 8'h80) begin
              phase_next = PH_BODY;
              if (literal_kind) rune_seen_next = 1'b1;
            end else if (text_byte inside {[8'hC2:8'hDF]}) begin
              cont_left_next = 2'd1;
              cp_next        = {16'b0, text_byte[4:0]};
              len_class_next = 2'd0;
              phase_next     = PH_UTF_CONT;
            end else if (text_byte inside {[8'hE0:8'hEF]}) begin
              cont_left_next = 2'd2;
              cp_next        = {17'b0, text_byte[3:0]};
              len_class_next = 2'd1;
              phase_next     = PH_UTF_CONT;
            end else if (text_byte inside {[8'hF0:8'hF4]}) begin
              cont_left_next = 2'd3;
              cp_next        = {18'b0, text_byte[2:0]};
              len_class_next = 2'd2;
              phase_next     = PH_UTF_CONT;
            end else begin
              go = GO_ERROR;
            end
          end
          PH_UTF_CONT: begin
            if (text_byte[7:6] != 2'b10) begin
              go = GO_ERROR;
            end else begin
              cp_next        = cp_shift;
              cont_left_next = cont_left - 2'd1;
              if (cont_left_next == 2'd0) begin
                if (cp_shift < min_val || !is_scalar(cp_shift)) begin
                  go = GO_ERROR;
                end else begin
                  phase_next = PH_BODY;
                  if (literal_kind) rune_seen_next = 1'b1;
                end
              end
            end
          end
          PH_ESC: begin
            if (text_byte == 8'h27 || text_byte == 8'h22 || text_byte == 8'h6E ||
                text_byte == 8'h72 || text_byte == 8'h74 || text_byte == 8'h5C ||
                text_byte == 8'h30) begin
              phase_next = PH_BODY;
              if (literal_kind) rune_seen_next = 1'b1;
            end else if (text_byte == 8'h78) begin
              phase_next = PH_HEX_HI;
            end else if (text_byte == 8'h75) begin
              phase_next = PH_U_OPEN;
            end else begin
              go = GO_ERROR;
            end
          end
          PH_HEX_HI: begin
            // first digit of \x is octal
            if (text_byte >= 8'h30 && text_byte <= 8'h37) phase_next = PH_HEX_LO;
            else go = GO_ERROR;
          end
          PH_HEX_LO: begin
            if (hex[4]) begin
              phase_next = PH_BODY;
              if (literal_kind) rune_seen_next = 1'b1;
            end else begin
              go = GO_ERROR;
            end
          end
          PH_U_OPEN: begin
            if (text_byte != 8'h7B) begin
              go = GO_ERROR;
            end else begin
              cp_next      = '0;
              us_pend_next = 1'b0;
              phase_next   = PH_U_FIRST;
            end
          end
          PH_U_FIRST: begin
            if (!hex[4]) begin
              go = GO_ERROR;
            end else begin
              cp_next    = {17'b0, hex[3:0]};
              phase_next = PH_U_DIGITS;
            end
          end
          PH_U_DIGITS: begin
            if (us_pend) begin
              // underscore must be followed by a digit
              if (!hex[4]) begin
                go = GO_ERROR;
              end else begin
                us_pend_next = 1'b0;
                cp_next      = acc[20:0];
                if (acc > 25'(SCALAR_MAX)) go = GO_ERROR;
              end
            end else if (text_byte == 8'h7D) begin
              if (is_scalar(cp)) begin
                phase_next = PH_BODY;
                if (literal_kind) rune_seen_next = 1'b1;
              end else begin
                go = GO_ERROR;
              end
            end else if (text_byte == 8'h5F) begin
              us_pend_next = 1'b1;
            end else if (!hex[4]) begin
              go = GO_ERROR;
            end else begin
              cp_next = acc[20:0];
              if (acc > 25'(SCALAR_MAX)) go = GO_ERROR;
            end
          end
          default: go = GO_ERROR;
        endcase

        if (go == GO_ON && text_ends) go = GO_ERROR;

        if (go == GO_ACCEPT) begin
          res.status = ST_ACCEPTED;
          res.length = byte_count_next;
          clear      = 1'b1;
        end else if (go == GO_ERROR) begin
          if (rec_closed_next || text_ends) begin
            res.status = ST_MALFORMED;
            res.length = rec_len_next;
            clear      = 1'b1;
          end else begin
            phase_next = PH_RECOVER;
          end
        end
      end
    endcase

    if (clear) begin
      phase_next      = PH_IDLE;
      cont_left_next  = '0;
      cp_next         = '0;
      len_class_next  = '0;
      us_pend_next    = 1'b0;
      rune_seen_next  = 1'b0;
      byte_count_next = '0;
      rec_len_next    = '0;
      rec_closed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      // a kind write drops any scan in progress
      literal_kind <= rst ? 1'b0 : cfg_wr_data;
      phase        <= PH_IDLE;
      cont_left    <= '0;
      cp           <= '0;
      len_class    <= '0;
      us_pend      <= 1'b0;
      rune_seen    <= 1'b0;
      byte_count   <= '0;
      rec_len      <= '0;
      rec_closed   <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      cont_left  <= cont_left_next;
      cp         <= cp_next;
      len_class  <= len_class_next;
      us_pend    <= us_pend_next;
      rune_seen  <= rune_seen_next;
      byte_count <= byte_count_next;
      rec_len    <= rec_len_next;
      rec_closed <= rec_closed_next;
    end
  end

endmodule

/* hw/rtl/quoted_literal_validator.sv */
// ----------------------------------------------------------------------------
// quoted_literal_validator
// Byte-serial checker for string and rune literals with UTF-8 and escapes.
// ----------------------------------------------------------------------------
//   port    dir   handshake      payload
//   text    in    valid/ready    text_byte[7:0], text_ends
//   scan    out   valid/ready    scan_status[1:0], covered_length[11:0]
//   cfg_*   in    write enable   cfg_wr_data = literal_kind
//
// One byte per cycle sustained while the scan port is ready; the result of a request is
// offered on the scan port after the input register and then the result register.
// The scan state loop updates once per byte.
// Reset clears the scan state and selects string literals.
// A stalled scan port holds both stages; text stays ready while a stage is free.
// ----------------------------------------------------------------------------
module quoted_literal_validator
  import qlv_pkg::*;
#(
  parameter int MAX_LITERAL_BYTES = 4095
) (
  input  logic        clk,
  input  logic        rst,
  qlv_text_if.sink    text,
  qlv_scan_if.source  scan,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_ends;
  logic       o_valid;
  scan_res_t  o_res;
  scan_res_t  res;
  logic       adv;
  logic       step;

  assign adv        = !o_valid || scan.ready;
  assign text.ready = !s1_valid || adv;
  assign step       = s1_valid && adv;

  qlv_core #(
    .MAX_LITERAL_BYTES(MAX_LITERAL_BYTES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .text_byte   (s1_byte),
    .text_ends   (s1_ends),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (text.ready) s1_valid <= text.valid;
      if (adv) o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_byte <= text.text_byte;
      s1_ends <= text.text_ends;
    end
    if (step) o_res <= res;
  end

  assign scan.valid          = o_valid;
  assign scan.scan_status    = o_res.status;
  assign scan.covered_length = o_res.length;

endmodule

/* tb/quoted_literal_validator_test.sv */
// ----------------------------------------------------------------------------
// quoted_literal_validator_test
// Feeds string and rune literals, good and broken, one byte per request, and
// checks every status and covered length against a cycle-free predictor.
// ----------------------------------------------------------------------------
module quoted_literal_validator_test;
  import qlv_pkg::*;

  localparam int          LEN_CAP  = 4095;
  localparam logic [7:0]  QUOTE_DQ = 8'h22;
  localparam logic [7:0]  QUOTE_SQ = 8'h27;
  localparam logic [7:0]  BSLASH   = 8'h5C;
  localparam logic [7:0]  TAB      = 8'h09;
  localparam logic [7:0]  LF       = 8'h0A;
  localparam logic [7:0]  CR       = 8'h0D;
  localparam bit          KIND_STRING = 1'b0;
  localparam bit          KIND_RUNE   = 1'b1;

  typedef enum logic [3:0] {
    SC_IDLE, SC_BODY, SC_ESCAPE, SC_HEX_HI, SC_HEX_LO,
    SC_U_BRACE, SC_U_FIRST, SC_U_MORE, SC_UTF_TAIL, SC_RECOVER
  } scan_phase_e;

  typedef enum logic [1:0] {OUT_MORE, OUT_ACCEPT, OUT_BAD} step_e;

  class literal_scoreboard;
    scan_res_t   pending_q[$];
    int          mismatches;
    bit          rune_mode;
    scan_phase_e phase;
    logic [1:0]  tail_left;
    int unsigned cp_acc;
    logic [1:0]  utf_class;
    bit          sep_pending;
    bit          rune_filled;
    logic [11:0] lit_len;
    logic [11:0] recov_len;
    bit          recov_closed;

    function new();
      mismatches = 0;
      rune_mode = KIND_STRING;
      clear_scan();
    endfunction

    function void clear_scan();
      phase = SC_IDLE;
      tail_left = 0;
      cp_acc = 0;
      utf_class = 0;
      sep_pending = 0;
      rune_filled = 0;
      lit_len = 0;
      recov_len = 0;
      recov_closed = 0;
    endfunction

    // A kind write drops any literal in progress.
    function void set_kind(bit kind);
      rune_mode = kind;
      clear_scan();
    endfunction

    function logic [11:0] bump(logic [11:0] x);
      return (x < LEN_CAP) ? x + 12'd1 : x;
    endfunction

    function int hex_val(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - 48;
      if (b >= "a" && b <= "f") return int'(b) - 87;
      if (b >= "A" && b <= "F") return int'(b) - 55;
      return -1;
    endfunction

    function bit scalar_ok(int unsigned v);
      return v <= 32'h10FFFF && !(v >= 32'hD800 && v <= 32'hDFFF);
    endfunction

    function step_e close_element();
      phase = SC_BODY;
      if (rune_mode) rune_filled = 1'b1;
      return OUT_MORE;
    endfunction

    function step_e open_element(logic [7:0] b);
      if (b == BSLASH) begin
        phase = SC_ESCAPE;
        return OUT_MORE;
      end
      if (b == TAB || b == LF || b == CR) return OUT_BAD;
      if (b < 8'h80) return close_element();
      if (b >= 8'hC2 && b <= 8'hDF) begin
        tail_left = 1; cp_acc = b & 8'h1F; utf_class = 0;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        tail_left = 2; cp_acc = b & 8'h0F; utf_class = 1;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        tail_left = 3; cp_acc = b & 8'h07; utf_class = 2;
      end else begin
        return OUT_BAD;
      end
      phase = SC_UTF_TAIL;
      return OUT_MORE;
    endfunction

    function step_e body_step(logic [7:0] b, logic [7:0] q);
      int d;
      int unsigned floor_v;
      int unsigned nxt;
      d = hex_val(b);
      case (phase)
        SC_BODY: begin
          if (rune_mode) begin
            if (rune_filled) return (b == q) ? OUT_ACCEPT : OUT_BAD;
            if (b == q) return OUT_BAD;
            return open_element(b);
          end
          if (b == q) return OUT_ACCEPT;
          return open_element(b);
        end
        SC_UTF_TAIL: begin
          if (b[7:6] != 2'b10) return OUT_BAD;
          cp_acc = ((cp_acc << 6) | b[5:0]) & 32'h1FFFFF;
          tail_left = tail_left - 2'd1;
          if (tail_left != 0) return OUT_MORE;
          floor_v = (utf_class == 0) ? 32'h80 : (utf_class == 1) ? 32'h800 : 32'h10000;
          if (cp_acc < floor_v) return OUT_BAD;
          if (!scalar_ok(cp_acc)) return OUT_BAD;
          return close_element();
        end
        SC_ESCAPE: begin
          if (b == QUOTE_SQ || b == QUOTE_DQ || b == "n" || b == "r" || b == "t" ||
              b == BSLASH || b == "0")
            return close_element();
          if (b == "x") begin
            phase = SC_HEX_HI;
            return OUT_MORE;
          end
          if (b == "u") begin
            phase = SC_U_BRACE;
            return OUT_MORE;
          end
          return OUT_BAD;
        end
        SC_HEX_HI: begin
          if (b >= "0" && b <= "7") begin
            phase = SC_HEX_LO;
            return OUT_MORE;
          end
          return OUT_BAD;
        end
        SC_HEX_LO: return (d >= 0) ? close_element() : OUT_BAD;
        SC_U_BRACE: begin
          if (b != "{") return OUT_BAD;
          cp_acc = 0;
          sep_pending = 0;
          phase = SC_U_FIRST;
          return OUT_MORE;
        end
        SC_U_FIRST: begin
          if (d < 0) return OUT_BAD;
          cp_acc = d;
          phase = SC_U_MORE;
          return OUT_MORE;
        end
        SC_U_MORE: begin
          if (sep_pending) begin
            if (d < 0) return OUT_BAD;
            sep_pending = 0;
          end else if (b == "}") begin
            return scalar_ok(cp_acc) ? close_element() : OUT_BAD;
          end else if (b == "_") begin
            sep_pending = 1;
            return OUT_MORE;
          end else if (d < 0) begin
            return OUT_BAD;
          end
          nxt = cp_acc * 16 + d;
          if (nxt > 32'h10FFFF) return OUT_BAD;
          cp_acc = nxt;
          return OUT_MORE;
        end
        default: return OUT_BAD;
      endcase
    endfunction

    function scan_res_t predict(logic [7:0] b, logic ends);
      logic [7:0] q;
      bit         term;
      step_e      go;
      scan_res_t  r;
      q = rune_mode ? QUOTE_SQ : QUOTE_DQ;
      term = (b == q || b == LF || b == CR);
      r.status = ST_PENDING;
      r.length = '0;
      if (phase == SC_IDLE) begin
        if (b != q) begin
          r.status = ST_NOT_LIT;
        end else begin
          clear_scan();
          phase = SC_BODY;
          lit_len = 1;
          recov_len = 1;
          if (ends) begin
            r.status = ST_MALFORMED;
            r.length = 1;
            clear_scan();
          end
        end
      end else if (phase == SC_RECOVER) begin
        if (term) begin
          r.status = ST_MALFORMED;
          r.length = recov_len;
          clear_scan();
        end else begin
          recov_len = bump(recov_len);
          if (ends) begin
            r.status = ST_MALFORMED;
            r.length = recov_len;
            clear_scan();
          end
        end
      end else begin
        lit_len = bump(lit_len);
        // The recovery run stops growing at the first quote or line break.
        if (!recov_closed) begin
          if (term) recov_closed = 1;
          else recov_len = bump(recov_len);
        end
        go = body_step(b, q);
        if (go == OUT_MORE && ends) go = OUT_BAD;
        if (go == OUT_ACCEPT) begin
          r.status = ST_ACCEPTED;
          r.length = lit_len;
          clear_scan();
        end else if (go == OUT_BAD) begin
          if (recov_closed || ends) begin
            r.status = ST_MALFORMED;
            r.length = recov_len;
            clear_scan();
          end else begin
            phase = SC_RECOVER;
          end
        end
      end
      return r;
    endfunction

    function void note_request(logic [7:0] b, logic ends);
      pending_q.push_back(predict(b, ends));
    endfunction

    function void check_result(logic [1:0] status, logic [11:0] length);
      scan_res_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected scan result: status %0d length %0d", status, length);
      end else begin
        want = pending_q.pop_front();
        if (want.status !== status || want.length !== length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("scan mismatch: expected status %0d length %0d, got status %0d length %0d",
                     want.status, want.length, status, length);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  qlv_text_if text_ch();
  qlv_scan_if scan_ch();

  quoted_literal_validator uut (
    .clk        (clk),
    .rst        (rst),
    .text       (text_ch),
    .scan       (scan_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  literal_scoreboard board;
  bit                stall_on;
  bit                cur_kind;
  int unsigned       bytes_sent;
  logic [7:0]        lit[$];

  string bad_escapes[8] = '{"\"\\u{110000}\"", "\"\\u{D800}\"", "\"\\u{_1}\"",
                            "\"\\u{1_}\"", "\"\\u{1__2}\"", "\"\\u{}\"",
                            "\"\\x80\"", "\"\\q\""};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("FAIL quoted_literal_validator");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (text_ch.valid && text_ch.ready)
        board.note_request(text_ch.text_byte, text_ch.text_ends);
      if (scan_ch.valid && scan_ch.ready)
        board.check_result(scan_ch.scan_status, scan_ch.covered_length);
    end
  end

  initial begin : scan_sink
    int hold;
    scan_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        scan_ch.ready = 1'b0;
        hold = $urandom_range(1, 11);
        repeat (hold - 1) @(negedge clk);
      end else begin
        scan_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic ends);
    int gap;
    if (stall_on && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      text_ch.valid = 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    text_ch.valid = 1'b1;
    text_ch.text_byte = b;
    text_ch.text_ends = ends;
    do @(posedge clk); while (!text_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_lit(bit end_last);
    for (int i = 0; i < lit.size(); i++)
      send_byte(lit[i], end_last && (i == lit.size() - 1));
    lit.delete();
  endtask

  // Hold the sender until every request has come back, then let the pipe settle.
  task automatic drain();
    @(negedge clk);
    text_ch.valid = 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_kind(bit kind);
    drain();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = kind;
    @(posedge clk);
    board.set_kind(kind);
    cur_kind = kind;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) lit.push_back(s[i]);
  endfunction

  function automatic void add_packed(logic [255:0] v, int n);
    for (int i = n - 1; i >= 0; i--) lit.push_back(v[8*i +: 8]);
  endfunction

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10;
  endfunction

  function automatic logic [7:0] quote_char();
    return (cur_kind == KIND_RUNE) ? QUOTE_SQ : QUOTE_DQ;
  endfunction

  function automatic void add_u_escape(int unsigned v);
    int n;
    n = 1;
    while (n < 8 && (v >> (4 * n)) != 0) n++;
    n += $urandom_range(0, 2);
    add_str("\\u{");
    for (int i = n - 1; i >= 0; i--) begin
      if (i != n - 1 && $urandom_range(0, 3) == 0) lit.push_back("_");
      lit.push_back(hex_char((v >> (4 * i)) & 15));
    end
    lit.push_back("}");
  endfunction

  function automatic void add_element();
    int unsigned v;
    logic [7:0]  lead;
    case ($urandom_range(0, 6))
      0: begin
        do v = $urandom_range(0, 127);
        while (v == quote_char() || v == BSLASH || v == TAB || v == LF || v == CR);
        lit.push_back(v);
      end
      1: begin
        lit.push_back($urandom_range(8'hC2, 8'hDF));
        lit.push_back($urandom_range(8'h80, 8'hBF));
      end
      2: begin
        lead = $urandom_range(8'hE0, 8'hEF);
        lit.push_back(lead);
        if (lead == 8'hE0) lit.push_back($urandom_range(8'hA0, 8'hBF));
        else if (lead == 8'hED) lit.push_back($urandom_range(8'h80, 8'h9F));
        else lit.push_back($urandom_range(8'h80, 8'hBF));
        lit.push_back($urandom_range(8'h80, 8'hBF));
      end
      3: begin
        lead = $urandom_range(8'hF0, 8'hF4);
        lit.push_back(lead);
        if (lead == 8'hF0) lit.push_back($urandom_range(8'h90, 8'hBF));
        else if (lead == 8'hF4) lit.push_back($urandom_range(8'h80, 8'h8F));
        else lit.push_back($urandom_range(8'h80, 8'hBF));
        lit.push_back($urandom_range(8'h80, 8'hBF));
        lit.push_back($urandom_range(8'h80, 8'hBF));
      end
      4: begin
        lit.push_back(BSLASH);
        case ($urandom_range(0, 6))
          0: lit.push_back(QUOTE_SQ);
          1: lit.push_back(QUOTE_DQ);
          2: lit.push_back("n");
          3: lit.push_back("r");
          4: lit.push_back("t");
          5: lit.push_back(BSLASH);
          default: lit.push_back("0");
        endcase
      end
      5: begin
        add_str("\\x");
        lit.push_back(hex_char($urandom_range(0, 7)));
        lit.push_back(hex_char($urandom_range(0, 15)));
      end
      default: begin
        if ($urandom_range(0, 2) == 0) v = $urandom_range(0, 255);
        else v = $urandom_range(0, 32'h10FFFF);
        if (v >= 32'hD800 && v <= 32'hDFFF) v = v ^ 32'h1000;
        add_u_escape(v);
      end
    endcase
  endfunction

  function automatic void add_bad_element();
    case ($urandom_range(0, 10))
      0: add_packed({8'hC0 | 8'($urandom_range(0, 1)), 8'h80}, 2);
      1: lit.push_back($urandom_range(8'hF5, 8'hFF));
      2: lit.push_back($urandom_range(8'h80, 8'hBF));
      3: add_packed({8'hE0, 8'($urandom_range(8'h80, 8'h9F)), 8'h80}, 3);
      4: add_packed({8'hED, 8'($urandom_range(8'hA0, 8'hBF)), 8'hBF}, 3);
      5: begin
        if ($urandom_range(0, 1)) add_packed({8'hF4, 8'($urandom_range(8'h90, 8'hBF)), 16'h8080}, 4);
        else add_packed({8'hF0, 8'($urandom_range(8'h80, 8'h8F)), 16'hBFBF}, 4);
      end
      6: add_packed({8'($urandom_range(8'hC2, 8'hF4)), 8'($urandom_range(8'h20, 8'h7E))}, 2);
      7: begin
        case ($urandom_range(0, 2))
          0: lit.push_back(TAB);
          1: lit.push_back(LF);
          default: lit.push_back(CR);
        endcase
      end
      8: begin
        case ($urandom_range(0, 3))
          0: add_str("\\q");
          1: add_str("\\a");
          2: add_str("\\z");
          default: add_str("\\U");
        endcase
      end
      9: begin
        if ($urandom_range(0, 1)) add_str("\\x8");
        else add_str("\\x1g");
      end
      default: begin
        case ($urandom_range(0, 9))
          0: add_str("\\u{}");
          1: add_str("\\u{_1}");
          2: add_str("\\u{1_}");
          3: add_str("\\u{1__2}");
          4: add_str("\\u{110000}");
          5: add_str("\\u{D800}");
          6: add_str("\\u{dfff}");
          7: add_str("\\u12");
          8: add_str("\\u{12");
          default: add_str("\\u{g}");
        endcase
      end
    endcase
  endfunction

  function automatic void build_good();
    int n;
    n = (cur_kind == KIND_RUNE) ? 1 : $urandom_range(0, 5);
    lit.push_back(quote_char());
    repeat (n) add_element();
    lit.push_back(quote_char());
  endfunction

  function automatic void build_bad();
    lit.push_back(quote_char());
    if (cur_kind == KIND_RUNE && $urandom_range(0, 2) == 0) begin
      // wrong element count: empty or two
      if ($urandom_range(0, 1)) repeat (2) add_element();
    end else begin
      if (cur_kind == KIND_STRING) repeat ($urandom_range(0, 2)) add_element();
      add_bad_element();
      if (cur_kind == KIND_STRING) repeat ($urandom_range(0, 2)) add_element();
    end
    lit.push_back(quote_char());
  endfunction

  task automatic run_random(int unsigned count);
    int unsigned stop_at;
    int          cut;
    bit          end_last;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      end_last = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: build_good();
        5, 6: build_bad();
        7: begin
          build_good();
          lit[$urandom_range(1, lit.size() - 1)] = $urandom_range(0, 255);
        end
        8: begin
          // truncate the text inside the literal
          build_good();
          cut = $urandom_range(1, lit.size() - 1);
          repeat (cut) void'(lit.pop_back());
          end_last = 1'b1;
        end
        default: begin
          repeat ($urandom_range(1, 6))
            send_byte($urandom_range(0, 255), $urandom_range(0, 3) == 0);
        end
      endcase
      send_lit(end_last);
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.text_byte = '0;
    text_ch.text_ends = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    stall_on = 1'b1;
    cur_kind = KIND_STRING;
    bytes_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_kind(KIND_STRING);
    add_str("x");
    add_packed({8'hFF, 8'h00}, 2);
    send_lit(1'b0);
    add_str("\"\"");
    send_lit(1'b0);
    add_str("\"\\'\\\"\\n\\r\\t\\\\\\0\"");
    send_lit(1'b0);
    add_str("\"\\x7f\\x0A\\x3F\"");
    send_lit(1'b0);
    add_str("\"\\u{10_FFFF}\\u{0}\\u{D7ff}\\u{e000}\"");
    send_lit(1'b0);
    // UTF-8 range edges of each sequence length
    add_packed({8'h22, 8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
                8'hEF, 8'hBF, 8'hBF}, 13);
    add_packed({8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h22}, 9);
    send_lit(1'b0);
    // overlong, surrogate, above the last scalar, bad lead
    add_packed({8'h22, 8'hC0, 8'h80, 8'h22}, 4);
    send_lit(1'b0);
    add_packed({8'h22, 8'hE0, 8'h80, 8'h80, 8'h22}, 5);
    send_lit(1'b0);
    add_packed({8'h22, 8'hED, 8'hA0, 8'h80, 8'h22}, 5);
    send_lit(1'b0);
    add_packed({8'h22, 8'hF4, 8'h90, 8'h80, 8'h80, 8'h22}, 6);
    send_lit(1'b0);
    add_packed({8'h22, 8'hF5, 8'h80, 8'h22}, 4);
    send_lit(1'b0);
    foreach (bad_escapes[i]) begin
      add_str(bad_escapes[i]);
      send_lit(1'b0);
    end
    add_packed({8'h22, "a", 8'h09, "b", 8'h22}, 5);
    send_lit(1'b0);
    add_packed({8'h22, "ab", 8'h0A, "cd"}, 6);
    send_lit(1'b0);
    // escaped quote ends the recovery run; the trailing quote opens at text end
    add_str("\"\\\"\\q\"");
    send_lit(1'b1);
    add_str("\"abc");
    send_lit(1'b1);
    add_str("\"\\qxyz");
    send_lit(1'b1);
    // leave a literal open, then abort it with a kind write
    add_str("\"ab");
    send_lit(1'b0);

    write_kind(KIND_RUNE);
    add_str("'a'");
    send_lit(1'b0);
    add_str("''");
    send_lit(1'b0);
    add_str("'ab'");
    send_lit(1'b0);
    add_str("'\\''");
    send_lit(1'b0);
    add_str("'\\u{1F600}'");
    send_lit(1'b0);
    add_packed({8'h27, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h27}, 6);
    send_lit(1'b0);
    add_str("'\\x41'");
    send_lit(1'b0);
    add_str("\"a");
    send_lit(1'b0);
    add_str("'");
    send_lit(1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      write_kind(ph[0] ? KIND_STRING : KIND_RUNE);
      if (ph == 3) stall_on = 1'b0;
      run_random(30);
      drain();
      run_random(30);
    end

    drain();
    if (board.pending_q.size() != 0) board.mismatches++;
    if (board.mismatches == 0) begin
      $display("PASS quoted_literal_validator");
    end else begin
      $display("FAIL quoted_literal_validator");
    end
    $finish;
  end

endmodule
